FILE: sv/ppdm_pkg.sv
// ppdm_pkg: shared constants, event codes and control structs of the pulse period and
// duty meter. No dependencies; compiled first.
package ppdm_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 16;

    localparam int TB_BITS         = 27;
    localparam int FRAC_BITS       = 8;
    localparam int FREQ_BITS       = 35;
    localparam int DUTY_BITS       = 14;
    localparam int DUTY_SCALE_BITS = 14;
    localparam int SUM_CAP_BITS    = 64;

    localparam logic [TB_BITS-1:0]   TB_RESET  = 27'd1000000;
    localparam logic [DUTY_BITS-1:0] DUTY_FULL = 14'd10000;

    typedef enum logic [1:0] {
        OP_RISE   = 2'd0,
        OP_FALL   = 2'd1,
        OP_REPORT = 2'd2
    } op_t;

    // commands into the edge tracker
    typedef struct packed {
        logic rise;
        logic fall;
        logic clear;
    } track_cmd_t;

endpackage

FILE: sv/ppdm_if.sv
// ppdm channel interfaces: event input, result output and timebase write channel.
// Depends on ppdm_pkg for the fixed field widths.
interface ppdm_in_if #(
    parameter int TIME_BITS = ppdm_pkg::TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           op;
    logic [TIME_BITS-1:0] timestamp;

    modport source (output valid, output op, output timestamp, input ready);
    modport sink   (input valid, input op, input timestamp, output ready);
endinterface

interface ppdm_out_if #(
    parameter int TIME_BITS = ppdm_pkg::TIME_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [ppdm_pkg::FREQ_BITS-1:0] frequency_q8;
    logic [ppdm_pkg::DUTY_BITS-1:0] duty_hundredths;
    logic [TIME_BITS-1:0]           period_ticks;
    logic [TIME_BITS-1:0]           high_ticks;
    logic [TIME_BITS-1:0]           low_ticks;
    logic [TIME_BITS-1:0]           record_time;

    modport source (output valid, output frequency_q8, output duty_hundredths,
                    output period_ticks, output high_ticks, output low_ticks,
                    output record_time, input ready);
    modport sink   (input valid, input frequency_q8, input duty_hundredths,
                    input period_ticks, input high_ticks, input low_ticks,
                    input record_time, output ready);
endinterface

interface ppdm_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ppdm_pkg::TB_BITS-1:0] timebase_hz;

    modport source (output valid, output timebase_hz, input ready);
    modport sink   (input valid, input timebase_hz, output ready);
endinterface

FILE: sv/pulse_period_duty_meter_unit.sv
// pulse_period_duty_meter_unit: top level of the pulse period and duty meter.
// Depends on ppdm_pkg, ppdm_if (channels), ppdm_track and ppdm_div.
//
// Event beats carry a rising edge, a falling edge or a report tick with a free-running
// timestamp. Edge beats update the high time, low time, last period and the period
// sum and count. A report tick after at least one complete cycle gives one result
// beat: frequency (timebase over truncated average period, unsigned Q8), duty in
// hundredths of a percent (saturated at 10000), the last spans and the report
// timestamp; the sum and count are cleared. Other report ticks and the unused event
// code give nothing. Results go through an output register, so a finished result may
// wait while the next event beat is taken. A report runs three divisions in turn on
// one shared bit-serial divider: the average, the frequency and the duty; a zero
// average skips the frequency division and a zero period or saturated duty skips the
// duty division. The event channel is not ready while a report runs. The timebase is
// written over its own channel, which is always ready.
module pulse_period_duty_meter_unit #(
    parameter int TIME_BITS  = ppdm_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = ppdm_pkg::COUNT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ppdm_in_if.sink    evt,
    ppdm_out_if.source res,
    ppdm_cfg_if.sink   cfg
);

    // sum width, capped where it would pass 64 bits (then it saturates)
    localparam int SUM_FULL = TIME_BITS + COUNT_BITS;
    localparam int SUM_BITS = (SUM_FULL > ppdm_pkg::SUM_CAP_BITS) ?
                              ppdm_pkg::SUM_CAP_BITS : SUM_FULL;
    localparam int PROD_W   = TIME_BITS + ppdm_pkg::DUTY_SCALE_BITS;
    localparam int DIV_W0   = (SUM_BITS > ppdm_pkg::FREQ_BITS) ?
                              SUM_BITS : ppdm_pkg::FREQ_BITS;
    localparam int DIV_W    = (DIV_W0 > PROD_W) ? DIV_W0 : PROD_W;
    localparam int DVS_W    = (TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS;
    localparam int STEP_W   = $clog2(DIV_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_FREQ,
        S_DUTY_SET,
        S_DUTY_GO,
        S_DUTY,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    // timebase register
    logic [ppdm_pkg::TB_BITS-1:0] timebase_reg;

    // tracker status
    ppdm_pkg::track_cmd_t  track_cmd;
    logic [TIME_BITS-1:0]  last_period;
    logic [TIME_BITS-1:0]  high_span;
    logic [TIME_BITS-1:0]  low_span;
    logic [SUM_BITS-1:0]   period_sum;
    logic [COUNT_BITS-1:0] period_count;
    logic                  cycle_done;

    // shared divider
    logic              div_start;
    logic [STEP_W-1:0] div_steps;
    logic [DIV_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [DIV_W-1:0]  div_q;
    logic              div_done;

    // working and result registers
    logic [PROD_W-1:0]                prod_reg, prod_next;
    logic [ppdm_pkg::FREQ_BITS-1:0]   freq_reg, freq_next;
    logic [ppdm_pkg::DUTY_BITS-1:0]   duty_reg, duty_next;
    logic [TIME_BITS-1:0]             stamp_reg, stamp_next;

    logic                             res_valid_reg, res_valid_next;
    logic [ppdm_pkg::FREQ_BITS-1:0]   res_freq_reg, res_freq_next;
    logic [ppdm_pkg::DUTY_BITS-1:0]   res_duty_reg, res_duty_next;
    logic [TIME_BITS-1:0]             res_period_reg, res_period_next;
    logic [TIME_BITS-1:0]             res_high_reg, res_high_next;
    logic [TIME_BITS-1:0]             res_low_reg, res_low_next;
    logic [TIME_BITS-1:0]             res_time_reg, res_time_next;

    logic evt_beat;
    logic is_rise;
    logic is_fall;
    logic report_go;
    logic avg_zero;

    assign evt.ready = (state_reg == S_IDLE);
    assign evt_beat  = evt.valid && evt.ready;
    assign is_rise   = (evt.op == ppdm_pkg::OP_RISE);
    assign is_fall   = (evt.op == ppdm_pkg::OP_FALL);
    // a report only counts once a full cycle has been seen
    assign report_go = evt_beat && (evt.op == ppdm_pkg::OP_REPORT) && cycle_done;
    assign avg_zero  = (div_q[TIME_BITS-1:0] == '0);

    // clear rides on the report beat: the divider latches sum and count at the same edge
    assign track_cmd.rise  = evt_beat && is_rise;
    assign track_cmd.fall  = evt_beat && is_fall;
    assign track_cmd.clear = report_go;

    // timebase write channel
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timebase_reg <= ppdm_pkg::TB_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            timebase_reg <= cfg.timebase_hz;
        end
    end

    ppdm_track #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (track_cmd),
        .ts           (evt.timestamp),
        .last_period  (last_period),
        .high_span    (high_span),
        .low_span     (low_span),
        .period_sum   (period_sum),
        .period_count (period_count),
        .cycle_done   (cycle_done)
    );

    ppdm_div #(
        .DIV_W  (DIV_W),
        .DVS_W  (DVS_W),
        .STEP_W (STEP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    // divider operand select, dividends left-aligned to the divider width
    always_comb
    begin
        div_start    = 1'b0;
        div_steps    = STEP_W'(SUM_BITS);
        div_dividend = DIV_W'(period_sum) << (DIV_W - SUM_BITS);
        div_divisor  = DVS_W'(period_count);
        unique case (state_reg)
            S_IDLE:
            begin
                div_start = report_go;
            end
            S_AVG:
            begin
                // frequency: timebase * 256 over the average period
                div_start    = div_done && !avg_zero;
                div_steps    = STEP_W'(ppdm_pkg::FREQ_BITS);
                div_dividend = DIV_W'({timebase_reg, {ppdm_pkg::FRAC_BITS{1'b0}}})
                               << (DIV_W - ppdm_pkg::FREQ_BITS);
                div_divisor  = DVS_W'(div_q[TIME_BITS-1:0]);
            end
            S_DUTY_GO:
            begin
                // duty: high * 10000 over the period
                div_start    = 1'b1;
                div_steps    = STEP_W'(PROD_W);
                div_dividend = DIV_W'(prod_reg) << (DIV_W - PROD_W);
                div_divisor  = DVS_W'(last_period);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        prod_next       = prod_reg;
        freq_next       = freq_reg;
        duty_next       = duty_reg;
        stamp_next      = stamp_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_freq_next   = res_freq_reg;
        res_duty_next   = res_duty_reg;
        res_period_next = res_period_reg;
        res_high_next   = res_high_reg;
        res_low_next    = res_low_reg;
        res_time_next   = res_time_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (report_go)
                begin
                    stamp_next = evt.timestamp;
                    state_next = S_AVG;
                end
            end
            S_AVG:
            begin
                if (div_done)
                begin
                    if (avg_zero)
                    begin
                        freq_next  = '0;
                        state_next = S_DUTY_SET;
                    end
                    else
                    begin
                        state_next = S_FREQ;
                    end
                end
            end
            S_FREQ:
            begin
                if (div_done)
                begin
                    freq_next  = div_q[ppdm_pkg::FREQ_BITS-1:0];
                    state_next = S_DUTY_SET;
                end
            end
            S_DUTY_SET:
            begin
                prod_next = PROD_W'(high_span) * PROD_W'(ppdm_pkg::DUTY_FULL);
                priority if (last_period == '0)
                begin
                    duty_next  = '0;
                    state_next = S_OUT;
                end
                else if (high_span >= last_period)
                begin
                    duty_next  = ppdm_pkg::DUTY_FULL;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DUTY_GO;
                end
            end
            S_DUTY_GO:
            begin
                state_next = S_DUTY;
            end
            S_DUTY:
            begin
                if (div_done)
                begin
                    duty_next  = div_q[ppdm_pkg::DUTY_BITS-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next  = 1'b1;
                    res_freq_next   = freq_reg;
                    res_duty_next   = duty_reg;
                    res_period_next = last_period;
                    res_high_next   = high_span;
                    res_low_next    = low_span;
                    res_time_next   = stamp_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        freq_reg       <= freq_next;
        duty_reg       <= duty_next;
        stamp_reg      <= stamp_next;
        res_freq_reg   <= res_freq_next;
        res_duty_reg   <= res_duty_next;
        res_period_reg <= res_period_next;
        res_high_reg   <= res_high_next;
        res_low_reg    <= res_low_next;
        res_time_reg   <= res_time_next;
    end

    assign res.valid           = res_valid_reg;
    assign res.frequency_q8    = res_freq_reg;
    assign res.duty_hundredths = res_duty_reg;
    assign res.period_ticks    = res_period_reg;
    assign res.high_ticks      = res_high_reg;
    assign res.low_ticks       = res_low_reg;
    assign res.record_time     = res_time_reg;

    // a report beat clears the completed-cycle flag
    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        report_go |=> !cycle_done)
        else $error("cycle flag still set after report");

    // the divider only finishes while a report is being worked
    a_div_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_AVG || state_reg == S_FREQ || state_reg == S_DUTY))
        else $error("divider finished outside a report");

    // every result beat has a duty within full scale
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_duty_reg <= ppdm_pkg::DUTY_FULL))
        else $error("duty above full scale");

endmodule

FILE: sv/ppdm_track.sv
// ppdm_track: edge timestamp tracking, high/low/period spans, period sum and count.
// Depends on ppdm_pkg (track_cmd_t).
module ppdm_track #(
    parameter int TIME_BITS  = ppdm_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = ppdm_pkg::COUNT_BITS_DEF,
    parameter int SUM_BITS   = TIME_BITS + COUNT_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppdm_pkg::track_cmd_t  cmd,
    input  logic [TIME_BITS-1:0]  ts,
    output logic [TIME_BITS-1:0]  last_period,
    output logic [TIME_BITS-1:0]  high_span,
    output logic [TIME_BITS-1:0]  low_span,
    output logic [SUM_BITS-1:0]   period_sum,
    output logic [COUNT_BITS-1:0] period_count,
    output logic                  cycle_done
);

    logic [TIME_BITS-1:0]  last_rise_reg, last_rise_next;
    logic [TIME_BITS-1:0]  last_fall_reg, last_fall_next;
    logic                  rise_seen_reg, rise_seen_next;
    logic                  fall_seen_reg, fall_seen_next;
    logic [TIME_BITS-1:0]  high_reg, high_next;
    logic [TIME_BITS-1:0]  low_reg, low_next;
    logic [TIME_BITS-1:0]  period_reg, period_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  done_reg, done_next;
    logic [TIME_BITS-1:0]  new_period;
    logic [SUM_BITS:0]     sum_add;

    assign new_period = ts - last_rise_reg;
    assign sum_add    = {1'b0, sum_reg} + (SUM_BITS + 1)'(new_period);

    always_comb
    begin
        last_rise_next = last_rise_reg;
        last_fall_next = last_fall_reg;
        rise_seen_next = rise_seen_reg;
        fall_seen_next = fall_seen_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        period_next    = period_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        if (cmd.rise)
        begin
            if (fall_seen_reg)
            begin
                low_next = ts - last_fall_reg;
            end
            if (rise_seen_reg)
            begin
                period_next = new_period;
                // count full: keep the average, stop accumulating
                if (count_reg != '1)
                begin
                    sum_next   = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
                    count_next = count_reg + 1'b1;
                end
                done_next = 1'b1;
            end
            last_rise_next = ts;
            rise_seen_next = 1'b1;
        end
        else if (cmd.fall)
        begin
            if (rise_seen_reg)
            begin
                high_next = ts - last_rise_reg;
            end
            last_fall_next = ts;
            fall_seen_next = 1'b1;
        end
        else if (cmd.clear)
        begin
            sum_next   = '0;
            count_next = '0;
            done_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rise_reg <= '0;
            last_fall_reg <= '0;
            rise_seen_reg <= 1'b0;
            fall_seen_reg <= 1'b0;
            high_reg      <= '0;
            low_reg       <= '0;
            period_reg    <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            last_rise_reg <= last_rise_next;
            last_fall_reg <= last_fall_next;
            rise_seen_reg <= rise_seen_next;
            fall_seen_reg <= fall_seen_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            period_reg    <= period_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    assign last_period  = period_reg;
    assign high_span    = high_reg;
    assign low_span     = low_reg;
    assign period_sum   = sum_reg;
    assign period_count = count_reg;
    assign cycle_done   = done_reg;

endmodule

FILE: sv/ppdm_div.sv
// ppdm_div: shared restoring divider, one quotient bit per cycle.
// The dividend arrives left-aligned; steps gives how many quotient bits to produce.
module ppdm_div #(
    parameter int DIV_W  = 78,
    parameter int DVS_W  = 32,
    parameter int STEP_W = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [STEP_W-1:0] steps,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic [DIV_W-1:0]  quotient,
    output logic              done
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] left_reg, left_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [DIV_W-1:0]  q_reg, q_next;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        left_next = left_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            left_next = steps;
            rem_next  = '0;
            dvs_next  = divisor;
            dvd_next  = dividend;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dvd_next  = dvd_reg << 1;
            q_next    = {q_reg[DIV_W-2:0], fits};
            left_next = left_reg - 1'b1;
            if (left_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule
